@@ design/fcba_pkg.sv @@
// Shared types and constants for the chained block allocator.
// No dependencies.
package fcba_pkg;

    // Default table size
    localparam int MAX_BLOCKS_DEF = 1024;

    // Widths fixed by the item and register fields
    localparam int CNT_W = 11;
    localparam int BLK_W = 10;
    localparam int PADDR_W = 3;

    // Register index and reset value
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] BCNT_RST = 11'd1024;

    // Operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_WALK    = 2'd2;

    // Configuration write toward the engine
    typedef struct packed {
        logic             wr;
        logic [CNT_W-1:0] value;
    } t_cfg_wr;

    // One finished result
    typedef struct packed {
        logic             status;
        logic [CNT_W-1:0] blocks_done;
        logic [BLK_W-1:0] next_block;
        logic [BLK_W-1:0] end_block;
        logic [CNT_W-1:0] chain_length;
    } t_result;

endpackage

@@ design/fat_chain_block_allocator_core.sv @@
// Chained block allocator: APB register port, item handshakes, result register.
// Walk and release visit each chain block in turn; allocate first walks to the tail,
// then scans the used bits and appends each free block it finds. Items are taken one
// at a time: a new item is accepted only after the result of the last one is taken.
// Synchronous active-low reset starts a clearing pass of the table memories during
// which no item is accepted.
module fat_chain_block_allocator_core #(
    parameter int MAX_BLOCKS = fcba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fcba_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_op,
    input  logic [fcba_pkg::BLK_W-1:0]         i_start_block,
    input  logic [fcba_pkg::CNT_W-1:0]         i_request_count,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_status,
    output logic [fcba_pkg::CNT_W-1:0]         o_blocks_done,
    output logic [fcba_pkg::BLK_W-1:0]         o_next_block,
    output logic [fcba_pkg::BLK_W-1:0]         o_end_block,
    output logic [fcba_pkg::CNT_W-1:0]         o_chain_length
);

    fcba_pkg::t_cfg_wr cfg;
    fcba_pkg::t_result res, r_out;
    logic [fcba_pkg::CNT_W-1:0] block_count;
    logic in_ready, res_valid, res_take;
    logic r_out_valid;

    // Register write decode
    assign pready = 1'b1;
    assign cfg.wr = psel && penable && pwrite && (paddr[2] == fcba_pkg::REG_BLOCK_COUNT);
    assign cfg.value = pwdata[fcba_pkg::CNT_W-1:0];
    assign prdata = (paddr[2] == fcba_pkg::REG_BLOCK_COUNT) ? 32'(block_count) : 32'd0;

    fcba_engine #(.MAX_BLOCKS(MAX_BLOCKS)) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .o_block_count   (block_count),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (in_ready),
        .i_op            (i_op),
        .i_start_block   (i_start_block),
        .i_request_count (i_request_count),
        .o_res_valid     (res_valid),
        .i_res_take      (res_take),
        .o_res           (res)
    );

    // Output register
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_in_stall = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_status = r_out.status;
    assign o_blocks_done = r_out.blocks_done;
    assign o_next_block = r_out.next_block;
    assign o_end_block = r_out.end_block;
    assign o_chain_length = r_out.chain_length;

endmodule

@@ design/fcba_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// Write-first on a same-address read. No dependencies.
module fcba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, new data when the same entry is written
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                o_rdata <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_raddr];
            end
        end
    end

endmodule

@@ design/fcba_engine.sv @@
// Sequencer for the allocator: table memories, free count and block count.
// Depends on fcba_pkg and fcba_ram.
module fcba_engine #(
    parameter int MAX_BLOCKS = fcba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fcba_pkg::t_cfg_wr               i_cfg,
    output logic [fcba_pkg::CNT_W-1:0]      o_block_count,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [fcba_pkg::BLK_W-1:0]      i_start_block,
    input  logic [fcba_pkg::CNT_W-1:0]      i_request_count,
    output logic                            o_res_valid,
    input  logic                            i_res_take,
    output fcba_pkg::t_result               o_res
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CW = (IDX_W + 1 > fcba_pkg::CNT_W) ? IDX_W + 1 : fcba_pkg::CNT_W;
    localparam int N_RST = (1024 > MAX_BLOCKS) ? MAX_BLOCKS : 1024;
    localparam logic [fcba_pkg::CNT_W-1:0] FREE_RST = fcba_pkg::CNT_W'(N_RST - 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

    localparam logic [1:0] OP_ALLOC_C   = fcba_pkg::OP_ALLOC;
    localparam logic [1:0] OP_RELEASE_C = fcba_pkg::OP_RELEASE;
    localparam logic [1:0] OP_WALK_C    = fcba_pkg::OP_WALK;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_ALC_WALK = 8'b0000_0100,
        S_ALC_SCAN = 8'b0000_1000,
        S_ALC_LINK = 8'b0001_0000,
        S_REL      = 8'b0010_0000,
        S_WALK     = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [fcba_pkg::CNT_W-1:0] r_block_count, n_block_count;
    logic [fcba_pkg::CNT_W-1:0] r_free, n_free;
    logic [fcba_pkg::CNT_W-1:0] r_req, n_req;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [CW-1:0] r_scan, n_scan;
    logic [CW-1:0] r_steps, n_steps;
    logic [CW-1:0] r_done, n_done;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_freed, n_freed;
    logic [IDX_W-1:0] r_nxt, n_nxt;
    logic [IDX_W-1:0] r_endb, n_endb;
    logic r_status, n_status;

    // Memory ports
    logic link_we, link_re, used_we, used_re;
    logic [IDX_W-1:0] link_waddr, link_raddr, used_waddr, used_raddr;
    logic [IDX_W-1:0] link_wdata, link_q;
    logic used_wdata, used_q;

    // Effective count and helpers
    logic [CW-1:0] bc_ext, n_eff, n_m1, cfg_ext, cfg_eff, start_ext, link_ext;
    logic [CW-1:0] scan_nx, done_nx, len_nx, freed_nx;
    logic [CW:0] rel_sum;
    logic [IDX_W-1:0] start_i, scan_i, scan_nx_i;
    logic start_ok, succ_ok;
    logic [fcba_pkg::CNT_W-1:0] req_clamp;

    always_comb begin
        bc_ext    = CW'(r_block_count);
        n_eff     = (bc_ext > MAX_C) ? MAX_C : bc_ext;
        n_m1      = (n_eff == '0) ? '0 : n_eff - CW'(1);
        cfg_ext   = CW'(i_cfg.value);
        cfg_eff   = (cfg_ext > MAX_C) ? MAX_C : cfg_ext;
        start_ext = CW'(i_start_block);
        start_i   = start_ext[IDX_W-1:0];
        start_ok  = (start_ext != '0) && (start_ext < n_eff);
        link_ext  = CW'(link_q);
        succ_ok   = (link_ext != '0) && (link_ext < n_eff);
        scan_i    = r_scan[IDX_W-1:0];
        scan_nx   = r_scan + CW'(1);
        scan_nx_i = scan_nx[IDX_W-1:0];
        done_nx   = r_done + CW'(1);
        len_nx    = r_len + CW'(1);
        freed_nx  = r_freed + CW'(used_q);
        rel_sum   = {1'b0, CW'(r_free)} + {1'b0, freed_nx};
        req_clamp = (i_request_count > r_free) ? r_free : i_request_count;
    end

    // Next-state and memory control
    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_block_count = r_block_count;
        n_free = r_free;
        n_req = r_req;
        n_cur = r_cur;
        n_scan = r_scan;
        n_steps = r_steps;
        n_done = r_done;
        n_len = r_len;
        n_freed = r_freed;
        n_nxt = r_nxt;
        n_endb = r_endb;
        n_status = r_status;
        link_we = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_re = 1'b0;
        link_raddr = '0;
        used_we = 1'b0;
        used_waddr = '0;
        used_wdata = 1'b0;
        used_re = 1'b0;
        used_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                link_we = 1'b1;
                link_waddr = r_clr;
                used_we = 1'b1;
                used_waddr = r_clr;
                used_wdata = (r_clr == '0);
                n_clr = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(MAX_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = 1'b0;
                    n_done = '0;
                    n_len = '0;
                    n_nxt = '0;
                    n_endb = '0;
                    n_freed = '0;
                    n_cur = start_i;
                    n_steps = CW'(1);
                    n_req = req_clamp;
                    n_state = S_FINISH;
                    case (i_op)
                        OP_ALLOC_C: begin
                            if (!start_ok) begin
                                n_status = 1'b1;
                            end else if (req_clamp != '0) begin
                                link_re = 1'b1;
                                link_raddr = start_i;
                                n_state = S_ALC_WALK;
                            end
                        end
                        OP_RELEASE_C: begin
                            if (!start_ok) begin
                                n_status = 1'b1;
                            end else begin
                                link_re = 1'b1;
                                link_raddr = start_i;
                                used_re = 1'b1;
                                used_raddr = start_i;
                                n_state = S_REL;
                            end
                        end
                        OP_WALK_C: begin
                            if (!start_ok) begin
                                n_status = 1'b1;
                            end else begin
                                link_re = 1'b1;
                                link_raddr = start_i;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_status = 1'b0;
                        end
                    endcase
                end
            end
            // Follow links to the tail of the chain
            S_ALC_WALK: begin
                if (succ_ok && (r_steps < n_eff)) begin
                    n_cur = link_q;
                    n_steps = r_steps + CW'(1);
                    link_re = 1'b1;
                    link_raddr = link_q;
                end else begin
                    n_scan = CW'(1);
                    used_re = 1'b1;
                    used_raddr = IDX_W'(1);
                    n_state = S_ALC_SCAN;
                end
            end
            // Look for the next clear used bit
            S_ALC_SCAN: begin
                if (!used_q) begin
                    link_we = 1'b1;
                    link_waddr = r_cur;
                    link_wdata = scan_i;
                    used_we = 1'b1;
                    used_waddr = scan_i;
                    used_wdata = 1'b1;
                    n_state = S_ALC_LINK;
                end else if (scan_nx < n_eff) begin
                    n_scan = scan_nx;
                    used_re = 1'b1;
                    used_raddr = scan_nx_i;
                end else begin
                    n_state = S_FINISH;
                end
            end
            // Terminate the new tail
            S_ALC_LINK: begin
                link_we = 1'b1;
                link_waddr = scan_i;
                n_cur = scan_i;
                n_done = done_nx;
                n_free = r_free - fcba_pkg::CNT_W'(1);
                if ((done_nx < CW'(r_req)) && (scan_nx < n_eff)) begin
                    n_scan = scan_nx;
                    used_re = 1'b1;
                    used_raddr = scan_nx_i;
                    n_state = S_ALC_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            // Clear each chain block
            S_REL: begin
                link_we = 1'b1;
                link_waddr = r_cur;
                used_we = 1'b1;
                used_waddr = r_cur;
                n_freed = freed_nx;
                n_done = done_nx;
                if (succ_ok && (done_nx < n_eff)) begin
                    n_cur = link_q;
                    link_re = 1'b1;
                    link_raddr = link_q;
                    used_re = 1'b1;
                    used_raddr = link_q;
                end else begin
                    n_free = (rel_sum > {1'b0, n_m1}) ? fcba_pkg::CNT_W'(n_m1)
                                                      : fcba_pkg::CNT_W'(rel_sum);
                    n_state = S_FINISH;
                end
            end
            S_WALK: begin
                if (r_len == '0) begin
                    n_nxt = succ_ok ? link_q : '0;
                end
                n_endb = r_cur;
                n_len = len_nx;
                if (succ_ok && (len_nx < n_eff)) begin
                    n_cur = link_q;
                    link_re = 1'b1;
                    link_raddr = link_q;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Register write: new count resets the free counter
        if (i_cfg.wr) begin
            n_block_count = i_cfg.value;
            n_free = (cfg_eff == '0) ? '0 : fcba_pkg::CNT_W'(cfg_eff - CW'(1));
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_block_count <= fcba_pkg::BCNT_RST;
            r_free <= FREE_RST;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_block_count <= n_block_count;
            r_free <= n_free;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_cur <= n_cur;
        r_scan <= n_scan;
        r_steps <= n_steps;
        r_done <= n_done;
        r_len <= n_len;
        r_freed <= n_freed;
        r_nxt <= n_nxt;
        r_endb <= n_endb;
        r_status <= n_status;
    end

    fcba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_q)
    );

    fcba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_re    (used_re),
        .i_raddr (used_raddr),
        .o_rdata (used_q)
    );

    // Outputs
    logic [CW-1:0] nxt_ext, endb_ext;
    assign nxt_ext = CW'(r_nxt);
    assign endb_ext = CW'(r_endb);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FINISH);
    assign o_block_count = r_block_count;
    assign o_res.status = r_status;
    assign o_res.blocks_done = r_done[fcba_pkg::CNT_W-1:0];
    assign o_res.next_block = nxt_ext[fcba_pkg::BLK_W-1:0];
    assign o_res.end_block = endb_ext[fcba_pkg::BLK_W-1:0];
    assign o_res.chain_length = r_len[fcba_pkg::CNT_W-1:0];

`ifndef NO_ASSERTIONS
    // Free count never exceeds the usable blocks
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (CW'(r_free) <= n_m1))
        else $error("free count above block count");

    // Scan pointer stays inside the table
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALC_SCAN) |-> ((r_scan != '0) && (r_scan < n_eff)))
        else $error("scan pointer out of range");

    // Allocation never exceeds the clamped request
    a_alloc_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ALC_SCAN) || (r_state == S_ALC_LINK)) |-> (r_done < CW'(r_req)))
        else $error("allocated past request");

    // No result goes out while the table is cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !$rose(o_res_valid))
        else $error("result during clearing pass");
`endif

endmodule
